// ===== src/dwr_pkg.sv =====
// dwr_pkg: shared sizes, operation codes and control structs for the deque.
// Used by dwr_cell, dwr_ctrl and deque_with_reverse; depends on nothing.
`default_nettype none

package dwr_pkg;

  // storage geometry
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;

  // channel widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_NONE       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REVERSE    = 3'd5
  } op_t;

  // commands broadcast to every cell (already gated by an accepted word)
  typedef struct packed {
    logic shift_up;    // physical push at cell 0, everything moves one up
    logic shift_down;  // physical pop at cell 0, everything moves one down
    logic load_last;   // physical push at cell [count]
  } cell_cmd_t;

  // controller state seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             reversed;
    logic             err;
    logic             valid;
  } ctrl_stat_t;

endpackage

`default_nettype wire

// ===== src/dwr_cell.sv =====
// dwr_cell: one storage cell of the deque row; holds one word and trades it
// with its neighbors. Depends on dwr_pkg.
`default_nettype none

module dwr_cell (
  input  wire                           clk,
  input  wire  dwr_pkg::cell_cmd_t      cmd,
  input  wire                           load_here,
  input  wire  [dwr_pkg::DATA_WIDTH-1:0] new_word,
  input  wire  [dwr_pkg::DATA_WIDTH-1:0] lower_word,
  input  wire  [dwr_pkg::DATA_WIDTH-1:0] upper_word,
  output logic [dwr_pkg::DATA_WIDTH-1:0] word
);

  logic [dwr_pkg::DATA_WIDTH-1:0] word_r;
  logic [dwr_pkg::DATA_WIDTH-1:0] word_nxt;

  // pick the incoming word; the commands never overlap
  always_comb begin
    priority if (load_here) begin
      word_nxt = new_word;
    end else if (cmd.shift_up) begin
      word_nxt = lower_word;
    end else if (cmd.shift_down) begin
      word_nxt = upper_word;
    end else begin
      word_nxt = word_r;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

`default_nettype wire

// ===== src/dwr_ctrl.sv =====
// dwr_ctrl: decodes operations, keeps fill count, reverse flag, error mark
// and result-valid state, and drives the cell commands. Depends on dwr_pkg.
`default_nettype none

module dwr_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          accept,
  input  wire  [dwr_pkg::OP_W-1:0]     op_bits,
  input  wire                          out_taken,
  output dwr_pkg::cell_cmd_t           cmd,
  output dwr_pkg::ctrl_stat_t          stat
);

  logic [dwr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      rev_r, rev_nxt;
  logic                      err_r, err_nxt;
  logic                      valid_r, valid_nxt;
  logic                      full, empty;
  logic                      push_first, push_last, pop_first, pop_last;
  dwr_pkg::op_t              op;

  assign op    = dwr_pkg::op_t'(op_bits);
  assign full  = (count_r == dwr_pkg::CNT_W'(dwr_pkg::DEPTH));
  assign empty = (count_r == '0);

  // map logical ends onto physical ends through the reverse flag
  always_comb begin
    push_first = 1'b0;
    push_last  = 1'b0;
    pop_first  = 1'b0;
    pop_last   = 1'b0;
    err_nxt    = 1'b0;
    rev_nxt    = rev_r;
    unique case (op)
      dwr_pkg::OP_PUSH_FRONT: begin
        err_nxt    = full;
        push_first = !full && !rev_r;
        push_last  = !full && rev_r;
      end
      dwr_pkg::OP_PUSH_BACK: begin
        err_nxt    = full;
        push_first = !full && rev_r;
        push_last  = !full && !rev_r;
      end
      dwr_pkg::OP_POP_FRONT: begin
        err_nxt    = empty;
        pop_first  = !empty && !rev_r;
        pop_last   = !empty && rev_r;
      end
      dwr_pkg::OP_POP_BACK: begin
        err_nxt    = empty;
        pop_first  = !empty && rev_r;
        pop_last   = !empty && !rev_r;
      end
      dwr_pkg::OP_REVERSE: begin
        rev_nxt = !rev_r;
      end
      default: begin
      end
    endcase
  end

  // cell commands, only on an accepted word
  assign cmd.shift_up   = accept && push_first;
  assign cmd.shift_down = accept && pop_first;
  assign cmd.load_last  = accept && push_last;

  // next state
  always_comb begin
    count_nxt = count_r;
    valid_nxt = valid_r && !out_taken;
    if (accept) begin
      valid_nxt = 1'b1;
      if (push_first || push_last) begin
        count_nxt = count_r + dwr_pkg::CNT_W'(1);
      end else if (pop_first || pop_last) begin
        count_nxt = count_r - dwr_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
      err_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
      if (accept) begin
        rev_r <= rev_nxt;
        err_r <= err_nxt;
      end
    end
  end

  assign stat.count    = count_r;
  assign stat.reversed = rev_r;
  assign stat.err      = err_r;
  assign stat.valid    = valid_r;

endmodule

`default_nettype wire

// ===== src/deque_with_reverse.sv =====
// deque_with_reverse: top level of a bounded double-ended queue with reverse.
// Depends on dwr_pkg, dwr_cell and dwr_ctrl.
//
// Usage:
//  - Input channel in_*: in_tuser[2:0] carries the operation (none, push
//    front, push back, pop front, pop back, reverse), in_tdata the word to
//    push. A word is taken when in_tvalid and in_tready are both high.
//  - Result channel out_*: one result word per input word, giving front and
//    back words, entry count, empty mark and error mark after the operation.
//  - Storage is a row of 16 cells; cell 0 is the physical first entry. A
//    physical push or pop at the first end shifts the whole row by one;
//    the last end is written or dropped at the fill count.
//  - The result is registered and appears in the cycle after the input is
//    taken. Throughput: one operation per cycle unless the receiver stalls;
//    the result register is freed and refilled in the same cycle when out_tready is high.
//  - When the receiver stalls, the result holds and in_tready drops until
//    the result is taken.
//  - Reset (rst_n low, synchronous) empties the queue and clears the reverse
//    flag and any pending result; cell contents are not cleared.
`default_nettype none

module deque_with_reverse (
  input  wire                              clk,
  input  wire                              rst_n,
  // slave side
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [dwr_pkg::IN_DATA_W-1:0]    in_tdata,   // [31:0] data_in
  input  wire  [dwr_pkg::OP_W-1:0]         in_tuser,   // [2:0] op
  // master side
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [dwr_pkg::OUT_DATA_W-1:0]   out_tdata   // [31:0] front_word,
                                                       // [63:32] back_word,
                                                       // [68:64] entry_count,
                                                       // [69] is_empty,
                                                       // [70] op_error, [71] 0
);

  logic                              accept;
  logic                              out_taken;
  dwr_pkg::cell_cmd_t                cmd;
  dwr_pkg::ctrl_stat_t               stat;
  logic [dwr_pkg::DATA_WIDTH-1:0]    words [dwr_pkg::DEPTH];
  logic [dwr_pkg::CNT_W-1:0]         last_off;
  logic [dwr_pkg::DATA_WIDTH-1:0]    first_word, last_word;
  logic [dwr_pkg::DATA_WIDTH-1:0]    front_word, back_word;
  logic                              is_empty;

  // handshake: result register frees and refills in the same cycle
  assign in_tready = !stat.valid || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign out_taken = stat.valid && out_tready;

  dwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .op_bits  (in_tuser),
    .out_taken(out_taken),
    .cmd      (cmd),
    .stat     (stat)
  );

  // row of cells
  for (genvar i = 0; i < dwr_pkg::DEPTH; i++) begin : g_cell
    logic [dwr_pkg::DATA_WIDTH-1:0] lower_w, upper_w;
    logic                           load_here;

    if (i == 0) begin : g_first
      assign lower_w = in_tdata[dwr_pkg::DATA_WIDTH-1:0];
    end else begin : g_mid
      assign lower_w = words[i-1];
    end
    if (i == dwr_pkg::DEPTH - 1) begin : g_top
      assign upper_w = words[i];
    end else begin : g_below
      assign upper_w = words[i+1];
    end

    assign load_here = cmd.load_last && (stat.count == dwr_pkg::CNT_W'(i));

    dwr_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .load_here (load_here),
      .new_word  (in_tdata[dwr_pkg::DATA_WIDTH-1:0]),
      .lower_word(lower_w),
      .upper_word(upper_w),
      .word      (words[i])
    );
  end

  // end words of the stored run, zero when empty
  assign is_empty = (stat.count == '0);
  assign last_off = stat.count - dwr_pkg::CNT_W'(1);
  assign first_word = is_empty ? '0 : words[0];
  assign last_word  = is_empty ? '0 : words[last_off[dwr_pkg::IDX_W-1:0]];

  assign front_word = stat.reversed ? last_word : first_word;
  assign back_word  = stat.reversed ? first_word : last_word;

  assign out_tvalid = stat.valid;
  assign out_tdata  = {1'b0, stat.err, is_empty, stat.count, back_word, front_word};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= dwr_pkg::CNT_W'(dwr_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while result stalled");

  a_reverse_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == dwr_pkg::OP_REVERSE) |=>
      (stat.reversed != $past(stat.reversed)) && (stat.count == $past(stat.count)))
    else $error("reverse did not toggle or changed the count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd.shift_up || cmd.load_last)) |=>
      (stat.count == $past(stat.count) + dwr_pkg::CNT_W'(1)) && !stat.err)
    else $error("push did not add one entry");

endmodule

`default_nettype wire

// ===== dv/deque_with_reverse_tb.sv =====
// deque_with_reverse_tb: self-checking testbench for the double-ended queue with reverse.
// Depends on dwr_pkg and deque_with_reverse; predicts every result word in-line.

module deque_with_reverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;   // cycles with no handshake on either channel
  localparam int unsigned DRAIN_WAIT  = 5;
  localparam int unsigned MAX_REPORTS = 10;

  // spare op codes, decoded as no operation
  localparam logic [dwr_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [dwr_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [dwr_pkg::DATA_WIDTH-1:0] front_word;
    logic [dwr_pkg::DATA_WIDTH-1:0] back_word;
    logic [dwr_pkg::CNT_W-1:0]      entry_count;
    logic                           is_empty;
    logic                           op_error;
  } deque_status_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [dwr_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [dwr_pkg::OP_W-1:0]       in_tuser   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [dwr_pkg::OUT_DATA_W-1:0] out_tdata;

  // predictor state: stored words in physical order, plus the view flag
  logic [dwr_pkg::DATA_WIDTH-1:0] stored_words[$];
  logic                           view_flipped = 1'b0;

  deque_status_t         pending_status[$];
  int unsigned           mismatch_count = 0;
  int unsigned           quiet_cycles   = 0;
  int unsigned           send_idle_pct  = 0;
  int unsigned           recv_idle_pct  = 0;

  deque_with_reverse u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // apply one operation to the predicted queue and return the status after it
  function automatic deque_status_t apply_deque_op(logic [dwr_pkg::OP_W-1:0] op,
                                                   logic [dwr_pkg::DATA_WIDTH-1:0] w);
    deque_status_t st;
    bit            full;
    bit            empty;
    full  = (stored_words.size() >= dwr_pkg::DEPTH);
    empty = (stored_words.size() == 0);
    st    = '0;
    case (op)
      dwr_pkg::OP_PUSH_FRONT: begin
        if (full) st.op_error = 1'b1;
        else if (view_flipped) stored_words.push_back(w);
        else stored_words.push_front(w);
      end
      dwr_pkg::OP_PUSH_BACK: begin
        if (full) st.op_error = 1'b1;
        else if (view_flipped) stored_words.push_front(w);
        else stored_words.push_back(w);
      end
      dwr_pkg::OP_POP_FRONT: begin
        if (empty) st.op_error = 1'b1;
        else if (view_flipped) void'(stored_words.pop_back());
        else void'(stored_words.pop_front());
      end
      dwr_pkg::OP_POP_BACK: begin
        if (empty) st.op_error = 1'b1;
        else if (view_flipped) void'(stored_words.pop_front());
        else void'(stored_words.pop_back());
      end
      dwr_pkg::OP_REVERSE: begin
        view_flipped = ~view_flipped;
      end
      default: ;
    endcase
    if (stored_words.size() != 0) begin
      // flipped view: logical front is the physical last word
      st.front_word = view_flipped ? stored_words[$] : stored_words[0];
      st.back_word  = view_flipped ? stored_words[0] : stored_words[$];
    end
    st.entry_count = dwr_pkg::CNT_W'(stored_words.size());
    st.is_empty    = (stored_words.size() == 0);
    return st;
  endfunction

  // sender side: optional idle gap, then hold the word until it is taken
  task automatic send_word(logic [dwr_pkg::OP_W-1:0] op, logic [dwr_pkg::DATA_WIDTH-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // receiver side: random back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // predict on input handshakes, check on output handshakes, watch for hangs
  always @(posedge clk) begin : monitor
    deque_status_t got_st;
    deque_status_t want_st;
    bit            in_hs;
    bit            out_hs;
    in_hs  = rst_n && in_tvalid && in_tready;
    out_hs = rst_n && out_tvalid && out_tready;
    if (in_hs) begin
      pending_status.push_back(apply_deque_op(in_tuser, in_tdata[dwr_pkg::DATA_WIDTH-1:0]));
    end
    if (out_hs) begin
      got_st.front_word  = out_tdata[31:0];
      got_st.back_word   = out_tdata[63:32];
      got_st.entry_count = out_tdata[68:64];
      got_st.is_empty    = out_tdata[69];
      got_st.op_error    = out_tdata[70];
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result word with none expected: %h", $realtime, out_tdata);
      end else begin
        want_st = pending_status.pop_front();
        if (got_st.front_word  !== want_st.front_word  ||
            got_st.back_word   !== want_st.back_word   ||
            got_st.entry_count !== want_st.entry_count ||
            got_st.is_empty    !== want_st.is_empty    ||
            got_st.op_error    !== want_st.op_error) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: mismatch front %h/%h back %h/%h count %0d/%0d",
                      " empty %b/%b err %b/%b"},
                     $realtime, want_st.front_word, got_st.front_word,
                     want_st.back_word, got_st.back_word,
                     want_st.entry_count, got_st.entry_count,
                     want_st.is_empty, got_st.is_empty,
                     want_st.op_error, got_st.op_error);
        end
      end
    end
    if (!rst_n || in_hs || out_hs) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // pops on an empty queue, reverse while empty, do-nothing codes
  task automatic test_empty_queue();
    send_word(dwr_pkg::OP_POP_FRONT, 32'h1234_5678);
    send_word(dwr_pkg::OP_POP_BACK,  32'hFFFF_FFFF);
    send_word(dwr_pkg::OP_NONE,      32'hA5A5_A5A5);
    send_word(OP_SPARE_6,            32'h5A5A_5A5A);
    send_word(OP_SPARE_7,            32'h0000_0001);
    send_word(dwr_pkg::OP_REVERSE,   32'h8000_0000);
  endtask

  // one stored word: front and back both show it
  task automatic test_single_word();
    send_word(dwr_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(dwr_pkg::OP_POP_BACK,   32'h0000_0000);
    send_word(dwr_pkg::OP_PUSH_BACK,  32'h0000_0000);
  endtask

  // fill to the limit across a reverse, then push into a full store at both ends
  task automatic test_full_store();
    int unsigned k;
    for (k = 0; k < dwr_pkg::DEPTH; k++) begin
      if (k == 7) send_word(dwr_pkg::OP_REVERSE, 32'h0);
      send_word(k[0] ? dwr_pkg::OP_PUSH_BACK : dwr_pkg::OP_PUSH_FRONT,
                {k[7:0], ~k[7:0], k[7:0], ~k[7:0]});
    end
    send_word(dwr_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_word(dwr_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
  endtask

  // random traffic that drifts between filling and draining
  task automatic test_random_traffic(int unsigned n_words);
    int unsigned                    k;
    int unsigned                    r;
    bit                             fill_bias;
    logic [dwr_pkg::OP_W-1:0]       op;
    logic [dwr_pkg::DATA_WIDTH-1:0] w;
    fill_bias = 1'b0;
    for (k = 0; k < n_words; k++) begin
      if (k % 32 == 0) fill_bias = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 4) op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
      else if (r < 10) op = dwr_pkg::OP_NONE;
      else if (r < 18) op = dwr_pkg::OP_REVERSE;
      else if (r < (fill_bias ? 78 : 40))
        op = $urandom_range(1) ? dwr_pkg::OP_PUSH_BACK : dwr_pkg::OP_PUSH_FRONT;
      else op = $urandom_range(1) ? dwr_pkg::OP_POP_BACK : dwr_pkg::OP_POP_FRONT;
      case ($urandom_range(7))
        0:       w = '0;
        1:       w = '1;
        default: w = $urandom;
      endcase
      send_word(op, w);
    end
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 62;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_single_word();
    test_full_store();

    test_random_traffic(200);
    send_idle_pct = 62;
    recv_idle_pct = 34;
    test_random_traffic(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);

    // drain outstanding results
    in_tvalid <= 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== deque_with_reverse.f =====
src/dwr_pkg.sv
src/dwr_cell.sv
src/dwr_ctrl.sv
src/deque_with_reverse.sv
dv/deque_with_reverse_tb.sv
